>>> src/ftnh_pkg.sv
`timescale 1ns / 1ps

package ftnh_pkg;

    // Spray counter table depth and index width.
    localparam int LINK_SLOTS = 1024;
    localparam int SLOT_W     = $clog2(LINK_SLOTS);

    // Field widths.
    localparam int STAGE_W = 3;
    localparam int HOST_W  = 16;
    localparam int FLOW_W  = 32;
    localparam int HOPS_W  = 4;
    localparam int PORT_W  = 6;
    localparam int RADIX_W = 7;
    localparam int MODE_W  = 2;
    localparam int HALF_W  = 6;
    localparam int WORD_W  = 32;

    // Hop stages.
    localparam logic [STAGE_W-1:0] STG_HOST_EDGE = 3'd0;
    localparam logic [STAGE_W-1:0] STG_EDGE_AGG  = 3'd1;
    localparam logic [STAGE_W-1:0] STG_AGG_EDGE  = 3'd2;
    localparam logic [STAGE_W-1:0] STG_AGG_CORE  = 3'd3;
    localparam logic [STAGE_W-1:0] STG_CORE_AGG  = 3'd4;
    localparam logic [STAGE_W-1:0] STG_DELIVERY  = 3'd5;

    // Uplink balance modes.
    localparam logic [MODE_W-1:0] MODE_SPRAY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HASH  = 2'd1;

    // Configuration register indexes.
    localparam logic CFG_RADIX = 1'b0;
    localparam logic CFG_MODE  = 1'b1;

    // Expected hop counts on delivery.
    localparam logic [HOPS_W-1:0] HOPS_RACK  = 4'd2;
    localparam logic [HOPS_W-1:0] HOPS_POD   = 4'd4;
    localparam logic [HOPS_W-1:0] HOPS_OTHER = 4'd6;

    // Divider command and status.
    typedef struct packed {
        logic start;
        logic long_op;
    } t_div_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> src/ftnh_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. A short operation divides
// the low 16 bits of the dividend, a long one all 32 bits.
module ftnh_div
    import ftnh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_cmd             i_cmd,
    input  logic [WORD_W-1:0]    i_dividend,
    input  logic [HALF_W-1:0]    i_divisor,
    output t_div_stat            o_stat,
    output logic [WORD_W-1:0]    o_quotient,
    output logic [HALF_W-1:0]    o_remainder
);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [4:0]         r_cnt, n_cnt;
    logic [WORD_W-1:0]  r_dvd, n_dvd;
    logic [HALF_W-1:0]  r_rem, n_rem;
    logic [HALF_W-1:0]  r_dsr, n_dsr;
    logic [HALF_W:0]    trial;
    logic [HALF_W:0]    diff;
    logic               q_bit;

    // One trial subtraction per cycle.
    always_comb begin
        trial = {r_rem, r_dvd[WORD_W-1]};
        diff  = trial - {1'b0, r_dsr};
        q_bit = (trial >= {1'b0, r_dsr});
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_rem  = '0;
            n_dsr  = i_divisor;
            if (i_cmd.long_op) begin
                n_dvd = i_dividend;
                n_cnt = 5'd31;
            end else begin
                n_dvd = {i_dividend[15:0], 16'd0};
                n_cnt = 5'd15;
            end
        end else if (r_busy) begin
            n_dvd = {r_dvd[WORD_W-2:0], q_bit};
            n_rem = q_bit ? diff[HALF_W-1:0] : trial[HALF_W-1:0];
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_dvd;
    assign o_remainder  = r_rem;

endmodule

>>> src/fat_tree_next_hop_port_select.sv
`timescale 1ns / 1ps

// Next-hop port selection for a k-ary fat tree. Each input transaction is
// one packet hop; the block returns one result transaction with the queue
// index in the next switch, an arbiter flag, a delivery flag and a hop-count
// mismatch flag. All divisions by k/2 run on one shared bit-serial divider.
// Each 16-bit division has a launch step and then waits for the divider's
// done. Four of them (racks and pods of both ends), then a decide and a
// finish step, make up one transaction. An uplink choice by spray or hash
// adds a 32-bit modulo. The block takes no new transaction until the
// current one is finished, but a finished result waits in the output
// register while the next one is accepted; a result stalled there holds
// the finish step longer. After reset the 1024-entry spray counter table
// is cleared one entry a cycle, and the input is not ready until that
// clearing pass ends; configuration writes are taken at any time the
// block is idle.
module fat_tree_next_hop_port_select
    import ftnh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port.
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [RADIX_W-1:0] i_cfg_wdata,
    // Input stream. tdata from bit 0: stage[2:0], src_host[18:3],
    // dst_host[34:19], flow_number[66:35], src_arbiter[67],
    // dst_arbiter[68], link_slot[78:69], hops_taken[82:79], zero pad.
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [87:0]        i_s_tdata,
    // Result stream. tdata from bit 0: out_port[5:0], to_arbiter[6],
    // delivered[7], hop_mismatch[8], zero pad.
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [15:0]        o_m_tdata
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAUNCH = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    // Divider operations.
    localparam logic [2:0] OP_DST  = 3'd0;
    localparam logic [2:0] OP_SRC  = 3'd1;
    localparam logic [2:0] OP_DPOD = 3'd2;
    localparam logic [2:0] OP_SPOD = 3'd3;
    localparam logic [2:0] OP_UP   = 3'd4;

    logic [RADIX_W-1:0] r_radix;
    logic [MODE_W-1:0]  r_mode;

    logic [2:0]         r_state, n_state;
    logic [2:0]         r_op, n_op;
    logic               r_clr_busy;
    logic [SLOT_W-1:0]  r_clr_idx;

    // Latched item.
    logic [STAGE_W-1:0] r_stage;
    logic [HOST_W-1:0]  r_src, r_dst;
    logic [FLOW_W-1:0]  r_flow;
    logic               r_sarb, r_darb;
    logic [SLOT_W-1:0]  r_slot;
    logic [HOPS_W-1:0]  r_hops;
    logic [HALF_W-1:0]  r_half;

    // Division results.
    logic [HOST_W-1:0]  r_q_dst, r_q_src;
    logic [HOST_W-1:0]  r_pod_dst, r_pod_src;
    logic [HALF_W-1:0]  r_dst_mod, r_rack_mod, r_up_mod;
    logic               r_up;
    logic [WORD_W-1:0]  r_up_val;

    logic               r_out_valid;
    logic [15:0]        r_out_data;

    // Spray counter memory.
    logic [WORD_W-1:0]  r_spray [LINK_SLOTS];
    logic [WORD_W-1:0]  r_rd_data;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;

    t_div_cmd           div_cmd;
    t_div_stat          div_stat;
    logic [WORD_W-1:0]  div_dvd;
    logic [WORD_W-1:0]  div_quo;
    logic [HALF_W-1:0]  div_rem;

    logic               s_accept;
    logic [RADIX_W-1:0] k_even;
    logic [HALF_W-1:0]  half_now;
    logic               same_rack, same_pod;
    logic               need_up, use_div;
    logic [PORT_W-1:0]  res_port;
    logic               res_arb, res_deliv, res_mism;
    logic [HOPS_W-1:0]  expect_hops;
    logic               out_free;

    ftnh_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (div_cmd),
        .i_dividend  (div_dvd),
        .i_divisor   (r_half),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= 7'd4;
            r_mode  <= MODE_SPRAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_RADIX: r_radix <= i_cfg_wdata;
                CFG_MODE:  r_mode  <= i_cfg_wdata[MODE_W-1:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    // Half radix: even part of k saturated to 4..64, then halved.
    always_comb begin
        k_even = r_radix & 7'h7E;
        if (k_even < 7'd4) begin
            half_now = 6'd2;
        end else if (k_even > 7'd64) begin
            half_now = 6'd32;
        end else begin
            half_now = k_even[6:1];
        end
    end

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE) && !r_clr_busy;
    assign out_free   = !r_out_valid || i_m_tready;

    // Rack and pod comparisons with arbiter endpoints taken as zero.
    always_comb begin
        same_rack = (r_sarb ? '0 : r_q_src) == (r_darb ? '0 : r_q_dst);
        same_pod  = (r_sarb ? '0 : r_pod_src) == (r_darb ? '0 : r_pod_dst);
        need_up   = ((r_stage == STG_HOST_EDGE) && !same_rack)
                 || ((r_stage == STG_EDGE_AGG) && !same_pod);
        use_div   = (r_mode == MODE_SPRAY) || (r_mode == MODE_HASH);
    end

    // Divider operand for the current operation.
    always_comb begin
        unique case (r_op)
            OP_DST:  div_dvd = {16'd0, r_dst};
            OP_SRC:  div_dvd = {16'd0, r_src};
            OP_DPOD: div_dvd = {16'd0, r_q_dst};
            OP_SPOD: div_dvd = {16'd0, r_q_src};
            default: div_dvd = r_up_val;
        endcase
        div_cmd.start   = (r_state == S_LAUNCH);
        div_cmd.long_op = (r_op == OP_UP);
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_LAUNCH;
                    n_op    = OP_DST;
                end
            end
            S_LAUNCH: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    priority if (r_op == OP_UP) begin
                        n_state = S_FIN;
                    end else if (r_op == OP_SPOD) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_op    = r_op + 3'd1;
                        n_state = S_LAUNCH;
                    end
                end
            end
            S_DECIDE: begin
                if (need_up && use_div) begin
                    n_op    = OP_UP;
                    n_state = S_LAUNCH;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_DST;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // Item capture, division results and uplink operand.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_stage <= i_s_tdata[2:0];
            r_src   <= i_s_tdata[18:3];
            r_dst   <= i_s_tdata[34:19];
            r_flow  <= i_s_tdata[66:35];
            r_sarb  <= i_s_tdata[67];
            r_darb  <= i_s_tdata[68];
            r_slot  <= i_s_tdata[78:69];
            r_hops  <= i_s_tdata[82:79];
            r_half  <= half_now;
        end
        if ((r_state == S_DIV) && div_stat.done) begin
            unique case (r_op)
                OP_DST: begin
                    r_q_dst   <= div_quo[HOST_W-1:0];
                    r_dst_mod <= div_rem;
                end
                OP_SRC: begin
                    r_q_src <= div_quo[HOST_W-1:0];
                end
                OP_DPOD: begin
                    r_pod_dst  <= div_quo[HOST_W-1:0];
                    r_rack_mod <= div_rem;
                end
                OP_SPOD: begin
                    r_pod_src <= div_quo[HOST_W-1:0];
                end
                default: begin
                    r_up_mod <= div_rem;
                end
            endcase
        end
        if (r_state == S_DECIDE) begin
            r_up <= need_up;
            if (r_mode == MODE_SPRAY) begin
                r_up_val <= r_rd_data;
            end else begin
                r_up_val <= {16'd0, r_src} + {16'd0, r_dst} + r_flow;
            end
            if (!use_div) begin
                r_up_mod <= '0;
            end
        end
    end

    // Clearing pass over the spray table after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + SLOT_W'(1);
            if (r_clr_idx == SLOT_W'(LINK_SLOTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Spray counter write: clear, or advance when a spray choice is made.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = r_rd_data + 32'd1;
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = '0;
        end else if ((r_state == S_DECIDE) && need_up && (r_mode == MODE_SPRAY)) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_spray[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_spray[r_slot];
    end

    // Result fields from the stage and the division results.
    always_comb begin
        res_port    = '0;
        res_arb     = 1'b0;
        res_deliv   = 1'b0;
        res_mism    = 1'b0;
        expect_hops = same_rack ? HOPS_RACK : (same_pod ? HOPS_POD : HOPS_OTHER);
        unique case (r_stage)
            STG_HOST_EDGE: begin
                if (r_up) begin
                    res_port = r_half + r_up_mod;
                end else if (r_darb) begin
                    res_arb = 1'b1;
                end else begin
                    res_port = r_dst_mod;
                end
            end
            STG_EDGE_AGG: begin
                if (r_up) begin
                    res_port = r_half + r_up_mod;
                end else begin
                    res_port = r_darb ? '0 : r_rack_mod;
                end
            end
            STG_AGG_EDGE: begin
                if (r_darb) begin
                    res_arb = 1'b1;
                end else begin
                    res_port = r_dst_mod;
                end
            end
            STG_AGG_CORE: begin
                res_port = r_darb ? '0 : r_pod_dst[PORT_W-1:0];
            end
            STG_CORE_AGG: begin
                res_port = r_darb ? '0 : r_rack_mod;
            end
            STG_DELIVERY: begin
                res_deliv = 1'b1;
                res_mism  = (r_hops != expect_hops);
            end
            default: begin
                res_port = '0;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if ((r_state == S_FIN) && out_free) begin
            r_out_data <= {7'd0, res_mism, res_deliv, res_arb, res_port};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> bench/fat_tree_hop_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both streams of the next-hop selector.
// It keeps its own copy of the registers and the spray counters, predicts
// one result per accepted input transaction, and compares each result
// transaction with the oldest prediction.
module fat_tree_hop_checker
    import ftnh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [RADIX_W-1:0] i_cfg_wdata,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [87:0]        i_s_tdata,
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [15:0]        i_m_tdata,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked
);

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic              to_arb;
        logic              delivered;
        logic              hop_mismatch;
    } t_hop_result;

    logic [RADIX_W-1:0] radix_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [31:0]        spray_cnt [LINK_SLOTS];
    t_hop_result        route_q [$];
    int                 err_count;
    int                 result_count;

    // Ports per direction: k with the low bit dropped, held to 4..64, halved.
    function automatic int unsigned ports_per_dir();
        logic [RADIX_W-1:0] k;
        k = radix_reg & 7'h7E;
        if (k < 7'd4) k = 7'd4;
        if (k > 7'd64) k = 7'd64;
        return int'(k >> 1);
    endfunction

    // Uplink offset; the spray counter of the link advances on every use in spray mode.
    function automatic int unsigned uplink_offset(logic [HOST_W-1:0] src,
                                                  logic [HOST_W-1:0] dst,
                                                  logic [FLOW_W-1:0] flow,
                                                  logic [SLOT_W-1:0] slot,
                                                  int unsigned half);
        logic [31:0] cnt;
        logic [31:0] sum;
        if (mode_reg == MODE_SPRAY) begin
            cnt = spray_cnt[slot];
            spray_cnt[slot] = cnt + 32'd1;
            return cnt % half;
        end
        if (mode_reg == MODE_HASH) begin
            sum = {16'b0, src} + {16'b0, dst} + flow;
            return sum % half;
        end
        return 0;
    endfunction

    // Predicts the result of one packet hop.
    function automatic t_hop_result route_hop(logic [87:0] word);
        logic [STAGE_W-1:0] stage;
        logic [HOST_W-1:0]  src, dst;
        logic [FLOW_W-1:0]  flow;
        logic               sarb, darb;
        logic [SLOT_W-1:0]  slot;
        logic [HOPS_W-1:0]  hops, want_hops;
        int unsigned        half, rack_s, rack_d, pod_s, pod_d, port;
        t_hop_result        res;
        stage = word[2:0];
        src   = word[18:3];
        dst   = word[34:19];
        flow  = word[66:35];
        sarb  = word[67];
        darb  = word[68];
        slot  = word[78:69];
        hops  = word[82:79];
        half   = ports_per_dir();
        rack_s = sarb ? 0 : src / half;
        rack_d = darb ? 0 : dst / half;
        pod_s  = sarb ? 0 : src / (half * half);
        pod_d  = darb ? 0 : dst / (half * half);
        port   = 0;
        res    = '0;
        case (stage)
            STG_HOST_EDGE: begin
                if (rack_s == rack_d) begin
                    if (darb) res.to_arb = 1'b1;
                    else port = dst % half;
                end else begin
                    port = half + uplink_offset(src, dst, flow, slot, half);
                end
            end
            STG_EDGE_AGG: begin
                if (pod_s == pod_d) port = rack_d % half;
                else port = half + uplink_offset(src, dst, flow, slot, half);
            end
            STG_AGG_EDGE: begin
                if (darb) res.to_arb = 1'b1;
                else port = dst % half;
            end
            STG_AGG_CORE: port = pod_d;
            STG_CORE_AGG: port = rack_d % half;
            STG_DELIVERY: begin
                want_hops = (rack_s == rack_d) ? HOPS_RACK :
                            (pod_s == pod_d) ? HOPS_POD : HOPS_OTHER;
                res.delivered    = 1'b1;
                res.hop_mismatch = (hops != want_hops);
            end
            default: ;
        endcase
        res.port = port[PORT_W-1:0];
        return res;
    endfunction

    // Track registers, predict on input transactions, compare on results.
    // Reports show the fields as port/arbiter/delivered/mismatch.
    always @(posedge i_clk) begin
        t_hop_result want, got;
        if (!i_rst_n) begin
            radix_reg = 7'd4;
            mode_reg  = MODE_SPRAY;
            foreach (spray_cnt[i]) spray_cnt[i] = '0;
            route_q.delete();
            err_count    = 0;
            result_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_RADIX) radix_reg = i_cfg_wdata;
                else if (i_cfg_addr == CFG_MODE) mode_reg = i_cfg_wdata[MODE_W-1:0];
            end
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[5:0], i_m_tdata[6], i_m_tdata[7], i_m_tdata[8]};
                result_count++;
                if (route_q.size() == 0) begin
                    if (err_count < 10)
                        $display("%0t: unexpected result %0d/%0b/%0b/%0b",
                                 $realtime, got.port, got.to_arb, got.delivered,
                                 got.hop_mismatch);
                    err_count++;
                end else begin
                    want = route_q.pop_front();
                    if (got !== want) begin
                        if (err_count < 10)
                            $display("%0t: expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
                                     $realtime, want.port, want.to_arb, want.delivered,
                                     want.hop_mismatch, got.port, got.to_arb,
                                     got.delivered, got.hop_mismatch);
                        err_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) route_q = {route_q, route_hop(i_s_tdata)};
        end
        o_errors  <= err_count;
        o_pending <= route_q.size();
        o_checked <= result_count;
    end

endmodule

>>> bench/tb_fat_tree_next_hop_port_select.sv
`timescale 1ns / 1ps

// Drives packet hops through the next-hop selector under a series of radix
// and balance settings, with random gaps on both streams.
module tb_fat_tree_next_hop_port_select;
    import ftnh_pkg::*;

    localparam logic [MODE_W-1:0] MODE_PORT_ZERO = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE     = 2'd3;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_HOPS  = 75;
    localparam int SETTLE_CYC  = 120;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_addr  = CFG_RADIX;
    logic [RADIX_W-1:0] cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [87:0]        s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [15:0]        m_tdata;

    int errors, pending, checked;
    int hops_sent = 0;
    bit calm = 1'b0;

    logic [RADIX_W-1:0] phase_radix [NUM_PHASES] =
        '{7'd4, 7'd8, 7'd64, 7'd127, 7'd0, 7'd6, 7'd65, 7'd16, 7'd2, 7'd64};
    logic [MODE_W-1:0] phase_mode [NUM_PHASES] =
        '{MODE_SPRAY, MODE_HASH, MODE_SPRAY, MODE_PORT_ZERO, MODE_SPARE,
          MODE_SPRAY, MODE_HASH, MODE_PORT_ZERO, MODE_HASH, MODE_SPRAY};

    fat_tree_next_hop_port_select dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    fat_tree_hop_checker u_hop_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Safety net against a hung handshake.
    initial begin
        #12_000_000;
        $display("[fat_tree_next_hop_port_select] ERROR");
        $finish;
    end

    // Packs one hop, stage in the lowest bits.
    function automatic logic [87:0] pack_hop(logic [STAGE_W-1:0] stage,
                                             logic [HOST_W-1:0] src,
                                             logic [HOST_W-1:0] dst,
                                             logic [FLOW_W-1:0] flow,
                                             logic sarb, logic darb,
                                             logic [SLOT_W-1:0] slot,
                                             logic [HOPS_W-1:0] hops);
        return {5'b0, hops, slot, darb, sarb, flow, dst, src, stage};
    endfunction

    function automatic int stim_half(logic [RADIX_W-1:0] radix);
        logic [RADIX_W-1:0] k;
        k = radix & 7'h7E;
        if (k < 7'd4) k = 7'd4;
        if (k > 7'd64) k = 7'd64;
        return int'(k >> 1);
    endfunction

    // Mostly hops between real hosts of the tree, often in the same rack or
    // pod, with a matching hop count on delivery; the rest is raw noise.
    function automatic logic [87:0] random_hop(int half);
        int span, pick, rs, rd, ps, pd;
        logic [STAGE_W-1:0] stage;
        logic [HOST_W-1:0]  src, dst;
        logic               sarb, darb;
        logic [SLOT_W-1:0]  slot;
        logic [HOPS_W-1:0]  hops;
        span = half * half * half * 2;
        if (span > 65536) span = 65536;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            stage = STAGE_W'($urandom_range(0, 5));
            src   = HOST_W'($urandom_range(0, span - 1));
            case ($urandom_range(0, 2))
                0: dst = HOST_W'((src / half) * half + $urandom_range(0, half - 1));
                1: dst = HOST_W'((src / (half * half)) * (half * half) +
                                 $urandom_range(0, half * half - 1));
                default: dst = HOST_W'($urandom_range(0, span - 1));
            endcase
            sarb = ($urandom_range(0, 9) == 0);
            darb = ($urandom_range(0, 9) == 0);
            slot = SLOT_W'($urandom_range(0, 7));
            hops = HOPS_W'($urandom_range(0, 15));
            if (stage == STG_DELIVERY && $urandom_range(0, 2) != 0) begin
                rs = sarb ? 0 : src / half;
                rd = darb ? 0 : dst / half;
                ps = sarb ? 0 : src / (half * half);
                pd = darb ? 0 : dst / (half * half);
                hops = (rs == rd) ? HOPS_RACK : (ps == pd) ? HOPS_POD : HOPS_OTHER;
            end
            return pack_hop(stage, src, dst, $urandom, sarb, darb, slot, hops);
        end
        if (pick < 95) stage = STAGE_W'($urandom_range(0, 5));
        else stage = STAGE_W'($urandom_range(6, 7));
        return pack_hop(stage, HOST_W'($urandom), HOST_W'($urandom), $urandom,
                        1'($urandom), 1'($urandom), SLOT_W'($urandom),
                        HOPS_W'($urandom));
    endfunction

    // One input transaction after a random gap.
    task automatic send_hop(input logic [87:0] word);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge i_clk); while (!s_tready);
        hops_sent++;
    endtask

    // Hold the input until every predicted result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_config(input logic [RADIX_W-1:0] radix,
                                input logic [MODE_W-1:0] mode);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_RADIX;
        cfg_wdata <= radix;
        @(posedge i_clk);
        cfg_addr  <= CFG_MODE;
        cfg_wdata <= RADIX_W'(mode);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stall before each transaction.
    initial begin
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    // Stimulus and verdict.
    initial begin
        int wait_cyc;
        int half;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The spray table is cleared after reset before input opens.
        for (wait_cyc = 0; wait_cyc < 1300 && !s_tready; wait_cyc++) @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                repeat (SETTLE_CYC) @(posedge i_clk);
                write_config(phase_radix[ph], phase_mode[ph]);
            end
            calm = (ph % 4 == 2);
            half = stim_half(phase_radix[ph]);

            // Directed corners under the reset settings (k = 4, spray).
            if (ph == 0) begin
                send_hop(pack_hop(STG_HOST_EDGE, 16'd0, 16'd1, 32'd0, 1'b0, 1'b0, 10'd0, 4'd0));
                send_hop(pack_hop(STG_HOST_EDGE, 16'd0, 16'd9, 32'd0, 1'b0, 1'b1, 10'd0, 4'd0));
                send_hop(pack_hop(STG_HOST_EDGE, 16'd0, 16'd5, 32'd0, 1'b0, 1'b0, 10'd0, 4'd0));
                send_hop(pack_hop(STG_HOST_EDGE, 16'd0, 16'd5, 32'd0, 1'b0, 1'b0, 10'd0, 4'd0));
                send_hop(pack_hop(STG_HOST_EDGE, 16'd77, 16'd1, 32'd0, 1'b1, 1'b0, 10'd0, 4'd0));
                send_hop(pack_hop(STG_EDGE_AGG, 16'd0, 16'd3, 32'd0, 1'b0, 1'b0, 10'd5, 4'd0));
                send_hop(pack_hop(STG_EDGE_AGG, 16'd0, 16'd100, 32'd0, 1'b0, 1'b0, 10'd1023, 4'd0));
                send_hop(pack_hop(STG_EDGE_AGG, 16'd0, 16'd100, 32'd0, 1'b0, 1'b0, 10'd1023, 4'd0));
                send_hop(pack_hop(STG_AGG_EDGE, 16'd0, 16'd7, 32'd0, 1'b0, 1'b0, 10'd0, 4'd0));
                send_hop(pack_hop(STG_AGG_EDGE, 16'd0, 16'd7, 32'd0, 1'b0, 1'b1, 10'd0, 4'd0));
                send_hop(pack_hop(STG_AGG_CORE, 16'd0, 16'hFFFF, 32'd0, 1'b0, 1'b0, 10'd0, 4'd0));
                send_hop(pack_hop(STG_CORE_AGG, 16'd0, 16'hFFFF, 32'd0, 1'b0, 1'b0, 10'd0, 4'd0));
                send_hop(pack_hop(STG_AGG_CORE, 16'd0, 16'hFFFF, 32'd0, 1'b0, 1'b1, 10'd0, 4'd0));
                send_hop(pack_hop(STG_DELIVERY, 16'd0, 16'd1, 32'd0, 1'b0, 1'b0, 10'd0, HOPS_RACK));
                send_hop(pack_hop(STG_DELIVERY, 16'd0, 16'd3, 32'd0, 1'b0, 1'b0, 10'd0, HOPS_POD));
                send_hop(pack_hop(STG_DELIVERY, 16'd0, 16'd100, 32'd0, 1'b0, 1'b0, 10'd0, HOPS_OTHER));
                send_hop(pack_hop(STG_DELIVERY, 16'd0, 16'd100, 32'd0, 1'b0, 1'b0, 10'd0, HOPS_RACK));
                send_hop(pack_hop(STG_DELIVERY, 16'hFFFF, 16'hFFFF, 32'd0, 1'b1, 1'b1, 10'd0, 4'd15));
                send_hop(pack_hop(STG_DELIVERY, 16'd0, 16'd1, 32'd0, 1'b0, 1'b0, 10'd0, 4'd0));
                send_hop(pack_hop(3'd6, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
                                  10'h3FF, 4'hF));
                send_hop(pack_hop(3'd7, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0, 10'd0, 4'd0));
                send_hop(pack_hop(STG_HOST_EDGE, 16'hFFFF, 16'd0, 32'hFFFF_FFFF, 1'b0, 1'b0,
                                  10'h3FF, 4'd0));
            end

            // Hash sum that wraps past 32 bits.
            if (ph == 1) begin
                send_hop(pack_hop(STG_HOST_EDGE, 16'hFFFF, 16'h0100, 32'hFFFF_FFFF, 1'b0, 1'b0,
                                  10'd0, 4'd0));
                send_hop(pack_hop(STG_EDGE_AGG, 16'hFFFF, 16'd0, 32'hFFFF_FFF0, 1'b0, 1'b0,
                                  10'd0, 4'd0));
                send_hop(pack_hop(STG_EDGE_AGG, 16'd0, 16'hFFFF, 32'd0, 1'b0, 1'b0,
                                  10'd0, 4'd0));
            end

            for (int n = 0; n < PHASE_HOPS; n++) begin
                // Let the result side empty out completely mid-phase.
                if (ph % 2 == 1 && n == 30) drain();
                send_hop(random_hop(half));
            end
        end

        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("Routed %0d packet hops under %0d radix and balance settings.",
                 hops_sent, NUM_PHASES);
        $display("Compared %0d result transactions, %0d mismatches.", checked, errors);
        if (errors == 0 && pending == 0) begin
            $display("[fat_tree_next_hop_port_select] OK");
        end else begin
            $display("[fat_tree_next_hop_port_select] ERROR");
        end
        $finish;
    end

endmodule
